// ===== rtl/core/owu_pkg.sv =====
// owu_pkg: shared types, register codes, defaults and the saturation helper
// for the optimizer weight update core; no dependencies
`default_nettype none

package owu_pkg;

  localparam int WEIGHT_COUNT_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int IDX_W  = 12;
  localparam int LR_W   = 21;
  localparam int MOM_W  = 17;
  localparam int EPS_W  = 16;
  localparam int L2_W   = 17;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [LR_W-1:0]  LR_RST  = LR_W'(655);
  localparam logic [MOM_W-1:0] MOM_RST = MOM_W'(58982);
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);
  localparam logic [L2_W-1:0]  L2_RST  = '0;

  typedef enum logic [1:0] {
    MODE_SGD      = 2'd0,
    MODE_MOMENTUM = 2'd1,
    MODE_ADAGRAD  = 2'd2,
    MODE_ADADELTA = 2'd3
  } opt_mode_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MODE = 3'd0,
    CFG_LR   = 3'd1,
    CFG_MOM  = 3'd2,
    CFG_EPS  = 3'd3,
    CFG_L2   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } ctl_state_e;

  typedef struct packed {
    logic [IDX_W-1:0]   weight_index;
    logic signed [31:0] weight_value;
    logic signed [31:0] grad_sum;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_index;
    logic signed [31:0] new_weight;
    logic               saturated;
  } out_req_t;

  localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;

  // returns {clip, value}
  function automatic logic [32:0] sat32(input logic signed [71:0] x);
    logic [32:0] r;
    if (x > SAT_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (x < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, x[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/optimizer_weight_update_core.sv =====
// optimizer_weight_update_core: per-weight sgd / momentum / adagrad / adadelta update
// depends on owu_pkg, owu_sqrt and owu_div
// the square root and divide pipes work one bit per stage
// throughput: one request per cycle while the output buffer is not full; a request
//   whose index is still in flight waits until that earlier request has written its
//   state back (not in sgd mode)
// reset: registers take their defaults, then a clearing pass over all WEIGHT_COUNT
//   entries zeroes both state memories while input is held off
`default_nettype none

module optimizer_weight_update_core #(
  parameter int WEIGHT_COUNT = owu_pkg::WEIGHT_COUNT_DEF,
  parameter int FRAC_BITS    = owu_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire owu_pkg::in_req_t              in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output owu_pkg::out_req_t                  out_req_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [owu_pkg::CFG_IW-1:0]    cfg_index_i,
  input  wire logic [owu_pkg::CFG_DW-1:0]    cfg_data_i
);

  import owu_pkg::*;

  localparam int AW    = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;
  localparam int SQW   = (33 + FRAC_BITS) / 2;
  localparam int NW    = 32 + ((LR_W > SQW) ? LR_W : SQW);
  localparam int OMW   = FRAC_BITS + 1;
  localparam int GGW   = 64 - FRAC_BITS;
  localparam int LRGW  = LR_W + 33;
  localparam int MVW   = 50;
  localparam int PRGW  = SQW + 33;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;

  typedef struct packed {
    logic                   vld;
    logic [IDX_W-1:0]       idx;
    logic                   instore;
    logic signed [31:0]     w;
    logic signed [31:0]     g;
    logic signed [LRGW-1:0] lrg;
    logic signed [31:0]     step01;
    logic signed [31:0]     s_step;
    logic signed [31:0]     s_sq;
    logic signed [MVW-1:0]  mv_f;
    logic signed [MVW-1:0]  l2w_f;
    logic                   apos;
    logic                   qneg;
    logic                   flag;
  } ctx_t;

  // configuration
  opt_mode_e        mode_q;
  logic [LR_W-1:0]  lr_q;
  logic [MOM_W-1:0] mom_q;
  logic [EPS_W-1:0] eps_q;
  logic [L2_W-1:0]  l2_q;
  logic [MOM_W-1:0] m_c;
  logic [OMW-1:0]   om_c;
  logic [EPS_W-1:0] eps_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SGD;
      lr_q   <= LR_RST;
      mom_q  <= MOM_RST;
      eps_q  <= EPS_RST;
      l2_q   <= L2_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE: mode_q <= opt_mode_e'(cfg_data_i[1:0]);
        CFG_LR:   lr_q   <= cfg_data_i[LR_W-1:0];
        CFG_MOM:  mom_q  <= cfg_data_i[MOM_W-1:0];
        CFG_EPS:  eps_q  <= cfg_data_i[EPS_W-1:0];
        CFG_L2:   l2_q   <= cfg_data_i[L2_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_c   = (32'(mom_q) > ONE32) ? MOM_W'(ONE32) : mom_q;
  assign om_c  = OMW'(ONE32 - 32'(m_c));
  assign eps_c = (eps_q == '0) ? EPS_W'(1) : eps_q;

  // control: clearing pass and flow
  ctl_state_e    state_q;
  logic [AW-1:0] clr_cnt_q;
  logic [1:0]    cnt_q;
  logic          en;
  logic          hz;
  logic          accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(WEIGHT_COUNT - 1)) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: ;
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  assign en         = (cnt_q != 2'd2);
  assign in_stall_o = (state_q != ST_RUN) || !en || ((mode_q != MODE_SGD) && hz);
  assign accept     = in_valid_i && !in_stall_o;

  // state memories
  logic signed [31:0] step_mem [WEIGHT_COUNT];
  logic signed [31:0] sq_mem   [WEIGHT_COUNT];
  logic signed [31:0] rd_step_q;
  logic signed [31:0] rd_sq_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] wr_step;
  logic signed [31:0] wr_sq;
  logic [AW-1:0]      raddr;

  assign raddr = AW'(in_req_i.weight_index);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      step_mem[mem_waddr] <= wr_step;
    end
    if (en) begin
      rd_step_q <= step_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sq_mem[mem_waddr] <= wr_sq;
    end
    if (en) begin
      rd_sq_q <= sq_mem[raddr];
    end
  end

  // stage 1: request and memory read
  logic    s1_vld_q;
  logic    s1_instore_q;
  in_req_t s1_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_req_q     <= in_req_i;
      s1_instore_q <= (32'(in_req_i.weight_index) < 32'(WEIGHT_COUNT));
    end
  end

  // stage 2: products
  logic signed [31:0]     s1_sstep;
  logic signed [31:0]     s1_ssq;
  logic                   s2_vld_q;
  logic [IDX_W-1:0]       s2_idx_q;
  logic                   s2_instore_q;
  logic signed [31:0]     s2_w_q;
  logic signed [31:0]     s2_g_q;
  logic signed [31:0]     s2_sstep_q;
  logic signed [31:0]     s2_ssq_q;
  logic signed [LRGW-1:0] s2_lrg_q;
  logic signed [63:0]     s2_gg_q;
  logic signed [MVW-1:0]  s2_mv_q;
  logic signed [MVW-1:0]  s2_msq_q;
  logic signed [MVW-1:0]  s2_l2w_q;
  logic signed [LR_W:0]   lr_s;
  logic signed [MOM_W:0]  m_s;
  logic signed [L2_W:0]   l2_s;

  assign s1_sstep = s1_instore_q ? rd_step_q : 32'sd0;
  assign s1_ssq   = s1_instore_q ? rd_sq_q : 32'sd0;
  assign lr_s     = {1'b0, lr_q};
  assign m_s      = {1'b0, m_c};
  assign l2_s     = {1'b0, l2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_idx_q     <= s1_req_q.weight_index;
      s2_instore_q <= s1_instore_q;
      s2_w_q       <= s1_req_q.weight_value;
      s2_g_q       <= s1_req_q.grad_sum;
      s2_sstep_q   <= s1_sstep;
      s2_ssq_q     <= s1_ssq;
      s2_lrg_q     <= lr_s * s1_req_q.grad_sum;
      s2_gg_q      <= s1_req_q.grad_sum * s1_req_q.grad_sum;
      s2_mv_q      <= m_s * s1_sstep;
      s2_msq_q     <= m_s * s1_ssq;
      s2_l2w_q     <= l2_s * s1_req_q.weight_value;
    end
  end

  // stage 3: sgd, momentum, adagrad accumulator
  logic signed [LRGW-1:0] lrg_f;
  logic [GGW-1:0]         gg_f;
  logic                   c0, c1, c2;
  logic signed [31:0]     st0, v1, a2;
  ctx_t                   s3_ctx_d;
  ctx_t                   s3_ctx_q;
  logic signed [31:0]     s3_a2_q;
  logic                   s3_c2_q;
  logic signed [MVW-1:0]  s3_msq_q;
  logic [OMW+GGW-1:0]     s3_omgg_q;

  assign lrg_f = s2_lrg_q >>> FRAC_BITS;
  assign gg_f  = GGW'($unsigned(s2_gg_q) >> FRAC_BITS);
  assign {c0, st0} = sat32(72'(lrg_f));
  assign {c1, v1}  = sat32(72'(s2_mv_q >>> FRAC_BITS) + 72'(lrg_f));
  assign {c2, a2}  = sat32(72'(s2_ssq_q) + 72'(gg_f));

  always_comb begin
    s3_ctx_d         = '0;
    s3_ctx_d.vld     = s2_vld_q;
    s3_ctx_d.idx     = s2_idx_q;
    s3_ctx_d.instore = s2_instore_q;
    s3_ctx_d.w       = s2_w_q;
    s3_ctx_d.g       = s2_g_q;
    s3_ctx_d.lrg     = s2_lrg_q;
    s3_ctx_d.step01  = (mode_q == MODE_MOMENTUM) ? v1 : st0;
    s3_ctx_d.s_step  = s2_sstep_q;
    s3_ctx_d.s_sq    = s2_ssq_q;
    s3_ctx_d.mv_f    = s2_mv_q >>> FRAC_BITS;
    s3_ctx_d.l2w_f   = s2_l2w_q >>> FRAC_BITS;
    s3_ctx_d.flag    = (mode_q == MODE_MOMENTUM) ? c1 : c0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctx_q <= '0;
    end else if (en) begin
      s3_ctx_q <= s3_ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_a2_q   <= a2;
      s3_c2_q   <= c2;
      s3_msq_q  <= s2_msq_q >>> FRAC_BITS;
      s3_omgg_q <= om_c * gg_f;
    end
  end

  // stage 4: adadelta accumulator, sqrt operands
  logic [OMW+GGW-FRAC_BITS-1:0] omgg_f;
  logic                         c3;
  logic signed [31:0]           eg3;
  logic signed [33:0]           x1, x2;
  ctx_t                         s4_ctx_d;
  ctx_t                         s4_ctx_q;
  logic [2*SQW-1:0]             rad1_q, rad2_q;

  assign omgg_f    = (OMW+GGW-FRAC_BITS)'(s3_omgg_q >> FRAC_BITS);
  assign {c3, eg3} = sat32(72'(s3_msq_q) + 72'(omgg_f));
  assign x1 = (mode_q == MODE_ADADELTA) ? (34'(s3_ctx_q.s_step) + 34'(eps_c))
                                        : 34'(s3_a2_q);
  assign x2 = 34'(eg3) + 34'(eps_c);

  always_comb begin
    s4_ctx_d = s3_ctx_q;
    case (mode_q)
      MODE_ADAGRAD: begin
        s4_ctx_d.s_sq = s3_a2_q;
        s4_ctx_d.flag = s3_c2_q;
        s4_ctx_d.apos = (s3_a2_q > 32'sd0);
      end
      MODE_ADADELTA: begin
        s4_ctx_d.s_sq = eg3;
        s4_ctx_d.flag = c3;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_ctx_q <= '0;
    end else if (en) begin
      s4_ctx_q <= s4_ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad1_q <= (x1 > 34'sd0) ? (2*SQW)'({x1[31:0], {FRAC_BITS{1'b0}}}) : '0;
      rad2_q <= (x2 > 34'sd0) ? (2*SQW)'({x2[31:0], {FRAC_BITS{1'b0}}}) : '0;
    end
  end

  // square roots
  logic [SQW-1:0] r1, r2;
  ctx_t           side_sq_q [SQW];

  owu_sqrt #(.RW(SQW)) u_sqrt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rad_i  (rad1_q),
    .root_o (r1)
  );

  owu_sqrt #(.RW(SQW)) u_sqrt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rad_i  (rad2_q),
    .root_o (r2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQW; k++) begin
        side_sq_q[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < SQW; k++) begin
        side_sq_q[k] <= (k == 0) ? s4_ctx_q : side_sq_q[k-1];
      end
    end
  end

  // stage 5: divide operands
  ctx_t                   s5_ctx_q;
  logic signed [PRGW-1:0] s5_prg_q;
  logic [SQW-1:0]         s5_den_q;
  logic signed [SQW:0]    r1_s;
  logic [SQW-1:0]         den5;

  assign r1_s = {1'b0, r1};

  always_comb begin
    if (mode_q == MODE_ADADELTA) begin
      den5 = (r2 == '0) ? SQW'(1) : r2;
    end else begin
      den5 = side_sq_q[SQW-1].apos ? r1 : SQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_ctx_q <= '0;
    end else if (en) begin
      s5_ctx_q <= side_sq_q[SQW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_prg_q <= r1_s * side_sq_q[SQW-1].g;
      s5_den_q <= den5;
    end
  end

  // stage 6: sign and magnitude
  logic signed [NW:0] num6;
  ctx_t               s6_ctx_d;
  ctx_t               s6_ctx_q;
  logic [NW-1:0]      s6_mag_q;
  logic [SQW-1:0]     s6_den_q;

  assign num6 = (mode_q == MODE_ADADELTA) ? (NW+1)'(s5_prg_q) : (NW+1)'(s5_ctx_q.lrg);

  always_comb begin
    s6_ctx_d      = s5_ctx_q;
    s6_ctx_d.qneg = num6[NW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_ctx_q <= '0;
    end else if (en) begin
      s6_ctx_q <= s6_ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_mag_q <= num6[NW] ? NW'(-num6) : NW'(num6);
      s6_den_q <= s5_den_q;
    end
  end

  // divide
  logic [NW-1:0] quo;
  ctx_t          side_dv_q [NW];

  owu_div #(.NW(NW), .DW(SQW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (s6_mag_q),
    .den_i  (s6_den_q),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) begin
        side_dv_q[k] <= '0;
      end
    end else if (en) begin
      for (int k = 0; k < NW; k++) begin
        side_dv_q[k] <= (k == 0) ? s6_ctx_q : side_dv_q[k-1];
      end
    end
  end

  // stage 7: signed step, step squared
  logic [71:0]        qs;
  logic               c4;
  logic signed [31:0] sd;
  ctx_t               s7_ctx_q;
  logic signed [31:0] s7_sd_q;
  logic               s7_c4_q;
  logic signed [63:0] s7_pss_q;

  assign qs = side_dv_q[NW-1].qneg ? (72'd0 - 72'(quo)) : 72'(quo);
  assign {c4, sd} = sat32(qs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_ctx_q <= '0;
    end else if (en) begin
      s7_ctx_q <= side_dv_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_sd_q  <= sd;
      s7_c4_q  <= c4;
      s7_pss_q <= sd * sd;
    end
  end

  // stage 8: decay of step squared
  logic [GGW-1:0]     ss_f;
  ctx_t               s8_ctx_q;
  logic signed [31:0] s8_sd_q;
  logic               s8_c4_q;
  logic [OMW+GGW-1:0] s8_omss_q;

  assign ss_f = GGW'($unsigned(s7_pss_q) >> FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_ctx_q <= '0;
    end else if (en) begin
      s8_ctx_q <= s7_ctx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_sd_q   <= s7_sd_q;
      s8_c4_q   <= s7_c4_q;
      s8_omss_q <= om_c * ss_f;
    end
  end

  // final: adadelta dx accumulator, new weight, write back
  logic [OMW+GGW-FRAC_BITS-1:0] omss_f;
  logic                         c5, c6;
  logic signed [31:0]           ex;
  logic signed [31:0]           step_f;
  logic signed [31:0]           nst_f;
  logic                         flag_f;
  logic signed [31:0]           nw;
  out_req_t                     res;
  logic                         push;

  assign omss_f   = (OMW+GGW-FRAC_BITS)'(s8_omss_q >> FRAC_BITS);
  assign {c5, ex} = sat32(72'(s8_ctx_q.mv_f) + 72'(omss_f));

  always_comb begin
    step_f = s8_ctx_q.step01;
    nst_f  = s8_ctx_q.step01;
    flag_f = s8_ctx_q.flag;
    case (mode_q)
      MODE_SGD, MODE_MOMENTUM: ;
      MODE_ADAGRAD: begin
        step_f = s8_ctx_q.apos ? s8_sd_q : 32'sd0;
        nst_f  = s8_ctx_q.s_step;
        flag_f = s8_ctx_q.flag | (s8_ctx_q.apos & s8_c4_q);
      end
      MODE_ADADELTA: begin
        step_f = s8_sd_q;
        nst_f  = ex;
        flag_f = s8_ctx_q.flag | s8_c4_q | c5;
      end
      default: ;
    endcase
  end

  assign {c6, nw} = sat32(72'(s8_ctx_q.w) + 72'(step_f) - 72'(s8_ctx_q.l2w_f));

  assign res.result_index = s8_ctx_q.idx;
  assign res.new_weight   = nw;
  assign res.saturated    = flag_f | c6;

  assign push = en && s8_ctx_q.vld;

  assign mem_we    = (state_q == ST_CLEAR) ||
                     (push && s8_ctx_q.instore && (mode_q != MODE_SGD));
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : AW'(s8_ctx_q.idx);
  assign wr_step   = (state_q == ST_CLEAR) ? 32'sd0 : nst_f;
  assign wr_sq     = (state_q == ST_CLEAR) ? 32'sd0 : s8_ctx_q.s_sq;

  // same-index interlock
  always_comb begin
    hz = 1'b0;
    if (s1_vld_q && (s1_req_q.weight_index == in_req_i.weight_index)) hz = 1'b1;
    if (s2_vld_q && (s2_idx_q == in_req_i.weight_index)) hz = 1'b1;
    if (s3_ctx_q.vld && (s3_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    if (s4_ctx_q.vld && (s4_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    if (s5_ctx_q.vld && (s5_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    if (s6_ctx_q.vld && (s6_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    if (s7_ctx_q.vld && (s7_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    if (s8_ctx_q.vld && (s8_ctx_q.idx == in_req_i.weight_index)) hz = 1'b1;
    for (int k = 0; k < SQW; k++) begin
      if (side_sq_q[k].vld && (side_sq_q[k].idx == in_req_i.weight_index)) hz = 1'b1;
    end
    for (int k = 0; k < NW; k++) begin
      if (side_dv_q[k].vld && (side_dv_q[k].idx == in_req_i.weight_index)) hz = 1'b1;
    end
  end

  // output buffer, two entries
  out_req_t fifo_q [2];
  logic     wr_ptr_q;
  logic     rd_ptr_q;
  logic     pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_RUN))
    else $error("request accepted during clearing pass");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s8_ctx_q.vld && (cnt_q == 2'd2) |=> $stable(s8_ctx_q.idx))
    else $error("result lost while output buffer full");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_we && (mode_q != MODE_SGD)) |-> (mem_waddr != raddr))
    else $error("state read overlaps write-back of same entry");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_vld_q)
    else $error("accepted request missing from pipeline");

endmodule

`default_nettype wire

// ===== rtl/core/owu_sqrt.sv =====
// owu_sqrt: pipelined integer square root, one root bit per stage
// self-contained, no package dependency
`default_nettype none

module owu_sqrt #(
  parameter int RW = 24
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [2*RW-1:0] rad_i,
  output logic      [RW-1:0]   root_o
);

  logic [2*RW-1:0] rad_q  [RW];
  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_d  [RW];
  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_d [RW];

  always_comb begin
    logic [2*RW-1:0] rad_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [RW+1:0]   rem_t;
    logic [RW+1:0]   trial;
    for (int k = 0; k < RW; k++) begin
      if (k == 0) begin
        rad_in  = rad_i;
        rem_in  = '0;
        root_in = '0;
      end else begin
        rad_in  = rad_q[k-1];
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
      end
      rem_t = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
      trial = {root_in, 2'b01};
      rad_d[k] = rad_in << 2;
      if (rem_t >= trial) begin
        rem_d[k]  = rem_t - trial;
        root_d[k] = {root_in[RW-2:0], 1'b1};
      end else begin
        rem_d[k]  = rem_t;
        root_d[k] = {root_in[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RW; k++) begin
        rad_q[k]  <= '0;
        rem_q[k]  <= '0;
        root_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < RW; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

`default_nettype wire

// ===== rtl/core/owu_div.sv =====
// owu_div: pipelined unsigned restoring divider, one quotient bit per stage
// self-contained, no package dependency
`default_nettype none

module owu_div #(
  parameter int NW = 56,
  parameter int DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic      [NW-1:0] quo_o
);

  logic [NW-1:0] num_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [NW-1:0] num_d [NW];
  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] quo_d [NW];

  always_comb begin
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   rem_t;
    logic [DW:0]   diff;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        num_in = num_i;
        den_in = den_i;
        rem_in = '0;
        quo_in = '0;
      end else begin
        num_in = num_q[k-1];
        den_in = den_q[k-1];
        rem_in = rem_q[k-1];
        quo_in = quo_q[k-1];
      end
      rem_t    = {rem_in, num_in[NW-1]};
      diff     = rem_t - {1'b0, den_in};
      num_d[k] = num_in << 1;
      if (rem_t >= {1'b0, den_in}) begin
        rem_d[k] = diff[DW-1:0];
        quo_d[k] = {quo_in[NW-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_t[DW-1:0];
        quo_d[k] = {quo_in[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW; k++) begin
        num_q[k] <= '0;
        den_q[k] <= '0;
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (en_i) begin
      for (int k = 0; k < NW; k++) begin
        num_q[k] <= num_d[k];
        den_q[k] <= (k == 0) ? den_i : den_q[k-1];
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[NW-1];

endmodule

`default_nettype wire

// ===== verif/owu_checker.sv =====
// owu_checker: watches the request, result and register channels of the core,
// predicts each updated weight and compares it with the result; uses owu_pkg
`timescale 1ns / 1ps

module owu_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_stall_i,
  input  wire owu_pkg::in_req_t           in_req_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_stall_i,
  input  wire owu_pkg::out_req_t          out_req_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [owu_pkg::CFG_IW-1:0] cfg_index_i,
  input  wire logic [owu_pkg::CFG_DW-1:0] cfg_data_i,
  output int                              errors_o,
  output int                              pending_o
);
  import owu_pkg::*;

  localparam longint ONE_FX = 64'sd65536;

  opt_mode_e          mode_q;
  logic [LR_W-1:0]    lr_q;
  logic [MOM_W-1:0]   mom_q;
  logic [EPS_W-1:0]   eps_q;
  logic [L2_W-1:0]    l2_q;
  logic signed [31:0] velocity_mem [4096];
  logic signed [31:0] sq_grad_mem  [4096];
  out_req_t           expected_updates [$];
  bit                 clipped;

  assign pending_o = expected_updates.size();

  function automatic longint floor_q16(input longint x);
    return (x >= 0) ? (x >>> 16) : -(((-x) + ONE_FX - 1) >>> 16);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return floor_q16(a * b);
  endfunction

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint qsqrt(input longint v);
    longint unsigned x, res, b;
    if (v <= 0) return 0;
    x = longint'(v) << 16;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  function automatic out_req_t update_weight(input in_req_t rq);
    out_req_t r;
    longint w, g, lr, m, om, eps, vel, acc, step, rdx, rg, nw;
    w = longint'(rq.weight_value);
    g = longint'(rq.grad_sum);
    lr = longint'(lr_q);
    m = (longint'(mom_q) > ONE_FX) ? ONE_FX : longint'(mom_q);
    om = ONE_FX - m;
    eps = (eps_q == 0) ? 1 : longint'(eps_q);
    vel = longint'(velocity_mem[rq.weight_index]);
    acc = longint'(sq_grad_mem[rq.weight_index]);
    step = 0;
    clipped = 1'b0;
    case (mode_q)
      MODE_SGD: step = clip32(qmul(lr, g));
      MODE_MOMENTUM: begin
        vel = clip32(qmul(m, vel) + qmul(lr, g));
        step = vel;
      end
      MODE_ADAGRAD: begin
        acc = clip32(acc + qmul(g, g));
        step = (acc > 0) ? clip32((lr * g) / qsqrt(acc)) : 0;
      end
      default: begin
        acc = clip32(qmul(m, acc) + qmul(om, qmul(g, g)));
        rdx = qsqrt(vel + eps);
        rg = qsqrt(acc + eps);
        if (rg < 1) rg = 1;
        step = clip32((rdx * g) / rg);
        vel = clip32(qmul(m, vel) + qmul(om, qmul(step, step)));
      end
    endcase
    if (mode_q != MODE_SGD) begin
      velocity_mem[rq.weight_index] = vel[31:0];
      sq_grad_mem[rq.weight_index] = acc[31:0];
    end
    nw = clip32(w + step - qmul(longint'(l2_q), w));
    r.result_index = rq.weight_index;
    r.new_weight = nw[31:0];
    r.saturated = clipped;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t exp_r;
    if (!rst_ni) begin
      mode_q <= MODE_SGD;
      lr_q <= LR_RST;
      mom_q <= MOM_RST;
      eps_q <= EPS_RST;
      l2_q <= L2_RST;
      errors_o <= 0;
      expected_updates.delete();
      for (int i = 0; i < 4096; i++) begin
        velocity_mem[i] = '0;
        sq_grad_mem[i] = '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODE: mode_q <= opt_mode_e'(cfg_data_i[1:0]);
          CFG_LR:   lr_q <= cfg_data_i[LR_W-1:0];
          CFG_MOM:  mom_q <= cfg_data_i[MOM_W-1:0];
          CFG_EPS:  eps_q <= cfg_data_i[EPS_W-1:0];
          CFG_L2:   l2_q <= cfg_data_i[L2_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_updates.push_back(update_weight(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_updates.size() == 0) begin
          $display("%0t: unexpected result idx=%0d w=%0d sat=%0d", $time,
                   out_req_i.result_index, out_req_i.new_weight, out_req_i.saturated);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_updates.pop_front();
          if (exp_r.result_index !== out_req_i.result_index ||
              exp_r.new_weight !== out_req_i.new_weight ||
              exp_r.saturated !== out_req_i.saturated) begin
            $display("%0t: mismatch expected idx=%0d w=%0d sat=%0d actual idx=%0d w=%0d sat=%0d",
                     $time, exp_r.result_index, exp_r.new_weight, exp_r.saturated,
                     out_req_i.result_index, out_req_i.new_weight, out_req_i.saturated);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// testbench: drives requests and register writes into the optimizer weight update
// core and gives the verdict; depends on owu_pkg and owu_checker
`timescale 1ns / 1ps

module testbench;
  import owu_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_req_t             in_req;
  logic                out_valid;
  logic                out_stall;
  out_req_t            out_req;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;
  int                  errors;
  int                  pending;
  bit                  no_idle;

  optimizer_weight_update_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_req_o(out_req),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  owu_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_req_i(out_req),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      int n;
      n = no_idle ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_request(input logic [IDX_W-1:0] idx, input logic [31:0] w,
                              input logic [31:0] g);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req.weight_index <= idx;
    in_req.weight_value <= w;
    in_req.grad_sum <= g;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      4: return 32'($urandom_range(0, 255)) - 32'd128;
      default: return 32'($urandom_range(0, 2097151)) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    return ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 15));
  endfunction

  task automatic set_config(input int p);
    logic [CFG_DW-1:0] lr, mom, eps, l2;
    lr = $urandom_range(0, 1048576);
    mom = $urandom_range(0, 65536);
    eps = $urandom_range(1, 65535);
    l2 = $urandom_range(0, 6000);
    case (p)
      1: begin lr = 0; mom = 0; eps = 0; l2 = 65536; end
      2: begin lr = 1048576; mom = 65536; eps = 65535; end
      3: begin lr = 2097151; mom = 131071; eps = 0; l2 = 131071; end
      5: begin mom = 0; l2 = 0; end
      6: begin mom = 65536; lr = 1048576; end
      default: ;
    endcase
    write_reg(CFG_MODE, CFG_DW'(p % 4));
    write_reg(CFG_LR, lr);
    write_reg(CFG_MOM, mom);
    write_reg(CFG_EPS, eps);
    write_reg(CFG_L2, l2);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero accumulator first, then field extremes in each mode
    for (int md = 0; md < 4; md++) begin
      if (md > 0) begin
        in_valid <= 1'b0;
        drain();
      end
      write_reg(CFG_MODE, CFG_DW'(md));
      send_request(IDX_W'(100 + md), 32'h0001_0000, 32'h0);
      send_request(12'hfff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(12'h000, 32'h8000_0000, 32'h8000_0000);
      send_request(12'h000, 32'h7fff_ffff, 32'h8000_0000);
      send_request(12'hfff, 32'h8000_0000, 32'h7fff_ffff);
    end

    for (int p = 0; p < 10; p++) begin
      in_valid <= 1'b0;
      drain();
      no_idle = (p % 3 == 2);
      set_config(p);
      for (int k = 0; k < 183; k++) begin
        if (k == 90) begin
          in_valid <= 1'b0;
          drain();
        end
        send_request(pick_index(), pick_value(), pick_value());
      end
    end
    in_valid <= 1'b0;
    drain();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
